// File: rtl/srcache_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srcache_pkg: shared types and helpers for the search result cache
// Slot layout, request/result records, codes and the mate score shift.
// ----------------------------------------------------------------------------
package srcache_pkg;

  localparam int INDEX_BITS = 12;
  localparam int SLOT_COUNT = 2 ** INDEX_BITS;

  localparam logic signed [33:0] MATE_WINDOW = 34'sd100000;

  // Request codes
  localparam logic [1:0] REQ_PROBE = 2'd0;
  localparam logic [1:0] REQ_STORE = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Bound codes
  localparam logic [1:0] BOUND_EXACT = 2'd0;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE      = 2'd0;
  localparam logic [1:0] CFG_AGE         = 2'd1;
  localparam logic [1:0] CFG_SCORE_LIMIT = 2'd2;

  localparam logic [30:0] SCORE_LIMIT_RST = 31'd1000000000;

  typedef logic [INDEX_BITS-1:0] idx_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [31:0] score;
    logic [7:0]  depth;
    logic [1:0]  bound;
    logic [15:0] move;
    logic [7:0]  age;
  } entry_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [63:0] key;
    logic [7:0]  depth;
    logic [7:0]  ply;
    logic [31:0] score;
    logic [1:0]  bound;
    logic [15:0] move;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] score;
    logic [7:0]  depth;
    logic [1:0]  bound;
    logic [15:0] move;
    logic [7:0]  age;
  } result_t;

  typedef struct packed {
    logic        enable;
    logic [7:0]  age;
    logic [30:0] score_limit;
  } cfg_t;

  // Shift a mate-range score by ply: toward the root on probe, away on store.
  function automatic logic [31:0] mate_adjust(input logic [31:0] score,
                                              input logic [7:0]  ply,
                                              input logic [30:0] score_limit,
                                              input logic        toward_root);
    logic signed [33:0] s_ext;
    logic signed [33:0] pos_thr;
    logic signed [33:0] neg_thr;
    logic [31:0]        ply_ext;
    logic [31:0]        res;
    s_ext   = {{2{score[31]}}, score};
    pos_thr = $signed({3'b000, score_limit}) - MATE_WINDOW;
    neg_thr = MATE_WINDOW - $signed({3'b000, score_limit});
    ply_ext = {24'd0, ply};
    res     = score;
    if (s_ext > pos_thr) begin
      res = toward_root ? (score - ply_ext) : (score + ply_ext);
    end else if (s_ext < neg_thr) begin
      res = toward_root ? (score + ply_ext) : (score - ply_ext);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: rtl/srcache_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srcache_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module srcache_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [$clog2(Depth)-1:0]        wr_addr,
  input  wire logic [Width-1:0]                wr_data,
  input  wire logic                            rd_en,
  input  wire logic [$clog2(Depth)-1:0]        rd_addr,
  output logic      [Width-1:0]                rd_data
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: rtl/srcache_decide.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srcache_decide: probe hit and store replacement decision
// Compares the request with the slot read from memory and builds the
// result record and the write-back entry.
// ----------------------------------------------------------------------------
module srcache_decide (
  input  wire srcache_pkg::req_t    req,
  input  wire srcache_pkg::entry_t  entry,
  input  wire srcache_pkg::cfg_t    cfg,
  output srcache_pkg::result_t      result,
  output logic                      wr_en,
  output srcache_pkg::entry_t       wr_entry
);

  logic same_key;
  logic deeper;
  logic same_depth;
  logic not_shallower;
  logic take;
  logic probe_hit;

  assign same_key      = (entry.key == req.key);
  assign deeper        = ($signed(req.depth) > $signed(entry.depth));
  assign same_depth    = (req.depth == entry.depth);
  assign not_shallower = ($signed(req.depth) >= $signed(entry.depth));

  always_comb begin
    if (!entry.valid) begin
      take = 1'b1;
    end else if (same_key) begin
      take = deeper || (same_depth && (req.bound == srcache_pkg::BOUND_EXACT)
                        && (entry.bound != srcache_pkg::BOUND_EXACT));
    end else begin
      take = (entry.age != cfg.age) || not_shallower
             || (req.bound == srcache_pkg::BOUND_EXACT);
    end
  end

  // stored depth must cover the required depth
  assign probe_hit = cfg.enable && (req.req_type == srcache_pkg::REQ_PROBE)
                     && entry.valid && same_key
                     && ($signed(entry.depth) >= $signed(req.depth));

  assign wr_en = cfg.enable && (req.req_type == srcache_pkg::REQ_STORE) && take;

  always_comb begin
    wr_entry.valid = 1'b1;
    wr_entry.key   = req.key;
    wr_entry.score = req.score;
    wr_entry.depth = req.depth;
    wr_entry.bound = req.bound;
    wr_entry.move  = req.move;
    wr_entry.age   = cfg.age;
  end

  always_comb begin
    result = '0;
    if (probe_hit) begin
      result.hit   = 1'b1;
      result.score = srcache_pkg::mate_adjust(entry.score, req.ply, cfg.score_limit, 1'b1);
      result.depth = entry.depth;
      result.bound = entry.bound;
      result.move  = entry.move;
      result.age   = entry.age;
    end else if (wr_en) begin
      result.hit   = 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/search_result_cache_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: the slot is read at the accepting edge, and the result is registered into
// the output register once that register is free (out_stall can hold it back).
// Only one transaction, a read-modify-write of the single slot memory, is in flight:
// a new one is taken after the last is done; a clear adds a sweep of SLOT_COUNT (4096) slots.
// Reset: synchronous active low; afterwards a sweep zeroes all 4096 slots before
// the first transaction is accepted. Config writes are taken whenever rst_n is high.
// ----------------------------------------------------------------------------
// search_result_cache_top: direct-mapped search result cache
// One slot memory, read-modify-write sequencer, config registers and an
// output register toward the result channel.
// ----------------------------------------------------------------------------
module search_result_cache_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [30:0]        cfg_wdata,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_req_type,
  input  wire logic [63:0]        in_lookup_key,
  input  wire logic signed [7:0]  in_depth,
  input  wire logic [7:0]         in_ply,
  input  wire logic signed [31:0] in_score_in,
  input  wire logic [1:0]         in_bound_in,
  input  wire logic [15:0]        in_move_in,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_hit,
  output logic signed [31:0]      out_score_out,
  output logic signed [7:0]       out_depth_out,
  output logic [1:0]              out_bound_out,
  output logic [15:0]             out_move_out,
  output logic [7:0]              out_age_out
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_CLEAR = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  srcache_pkg::idx_t     clr_cnt_r, clr_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  srcache_pkg::result_t  out_r;
  srcache_pkg::req_t     req_r;
  srcache_pkg::cfg_t     cfg_r;

  srcache_pkg::entry_t   rd_entry;
  srcache_pkg::entry_t   wr_entry;
  srcache_pkg::entry_t   ram_wdata;
  srcache_pkg::result_t  dec_result;
  srcache_pkg::idx_t     ram_waddr;
  logic                  dec_wr_en;
  logic                  ram_we;
  logic                  accept;
  logic                  load_out;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_out = (state_r == ST_EXEC) && (!out_valid_r || !out_stall);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable      <= 1'b1;
      cfg_r.age         <= 8'd0;
      cfg_r.score_limit <= srcache_pkg::SCORE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        srcache_pkg::CFG_ENABLE:      cfg_r.enable      <= cfg_wdata[0];
        srcache_pkg::CFG_AGE:         cfg_r.age         <= cfg_wdata[7:0];
        srcache_pkg::CFG_SCORE_LIMIT: cfg_r.score_limit <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // capture the request; store scores are shifted away from the root up front
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.req_type <= in_req_type;
      req_r.key      <= in_lookup_key;
      req_r.depth    <= in_depth;
      req_r.ply      <= in_ply;
      req_r.score    <= (in_req_type == srcache_pkg::REQ_STORE)
                        ? srcache_pkg::mate_adjust(in_score_in, in_ply, cfg_r.score_limit,
                                                   1'b0)
                        : in_score_in;
      req_r.bound    <= in_bound_in;
      req_r.move     <= in_move_in;
    end
  end

  srcache_decide u_decide (
    .req      (req_r),
    .entry    (rd_entry),
    .cfg      (cfg_r),
    .result   (dec_result),
    .wr_en    (dec_wr_en),
    .wr_entry (wr_entry)
  );

  // write port: clear sweep or store write-back
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else begin
      ram_we    = load_out && dec_wr_en;
      ram_waddr = req_r.key[srcache_pkg::INDEX_BITS-1:0];
      ram_wdata = wr_entry;
    end
  end

  srcache_ram #(
    .Width ($bits(srcache_pkg::entry_t)),
    .Depth (srcache_pkg::SLOT_COUNT)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (accept),
    .rd_addr (in_lookup_key[srcache_pkg::INDEX_BITS-1:0]),
    .rd_data (rd_entry)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the output register is free
        if (load_out) begin
          out_valid_nxt = 1'b1;
          clr_cnt_nxt   = '0;
          state_nxt     = (req_r.req_type == srcache_pkg::REQ_CLEAR) ? ST_CLEAR : ST_IDLE;
        end
      end
      ST_CLEAR: begin
        clr_cnt_nxt = srcache_pkg::idx_t'(clr_cnt_r + 1'b1);
        if (clr_cnt_r == {srcache_pkg::INDEX_BITS{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= dec_result;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = out_r.hit;
  assign out_score_out = $signed(out_r.score);
  assign out_depth_out = $signed(out_r.depth);
  assign out_bound_out = out_r.bound;
  assign out_move_out  = out_r.move;
  assign out_age_out   = out_r.age;

endmodule
`default_nettype wire

// File: dv/search_result_cache_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// search_result_cache_top_test: self-checking bench for the search result cache
// Drives probe, store, clear and spare requests through the valid/stall
// channel. Each accepted transaction is predicted by a cache model kept here,
// and each result is compared field by field. A directed table comes first,
// then random phases under different register settings.
// ----------------------------------------------------------------------------
module search_result_cache_top_test;

  localparam logic [1:0] REQ_SPARE   = 2'd3;
  localparam logic [1:0] BOUND_LOWER = 2'd1;
  localparam logic [1:0] BOUND_UPPER = 2'd2;
  localparam logic [1:0] BOUND_ODD   = 2'd3;

  localparam logic [63:0] KEY_ZERO       = 64'h0000_0000_0000_0000;
  localparam logic [63:0] KEY_ZERO_ALIAS = 64'h0000_0000_0000_1000;
  localparam logic [63:0] KEY_ONE        = 64'h0000_0000_0000_0001;
  localparam logic [63:0] KEY_ONE_ALIAS  = 64'hFFFF_FFFF_FFFF_F001;
  localparam logic [63:0] KEY_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam srcache_pkg::result_t MISS  = '0;
  localparam srcache_pkg::result_t WROTE = {1'b1, 66'd0};
  localparam bit TYPED     = 1'b1;
  localparam bit PREDICTED = 1'b0;

  localparam int POOL_SIZE  = 24;
  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 250;

  typedef enum logic {ROW_REQ, ROW_REGS} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    srcache_pkg::req_t    rq;
    bit                   typed;
    srcache_pkg::result_t reply;
    srcache_pkg::cfg_t    regs;
  } plan_row_t;

  logic               clk;
  logic               rst_n         = 1'b0;
  logic               cfg_we        = 1'b0;
  logic [1:0]         cfg_index     = srcache_pkg::CFG_ENABLE;
  logic [30:0]        cfg_wdata     = '0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [1:0]         in_req_type   = srcache_pkg::REQ_PROBE;
  logic [63:0]        in_lookup_key = '0;
  logic signed [7:0]  in_depth      = '0;
  logic [7:0]         in_ply        = '0;
  logic signed [31:0] in_score_in   = '0;
  logic [1:0]         in_bound_in   = srcache_pkg::BOUND_EXACT;
  logic [15:0]        in_move_in    = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic               out_hit;
  logic signed [31:0] out_score_out;
  logic signed [7:0]  out_depth_out;
  logic [1:0]         out_bound_out;
  logic [15:0]        out_move_out;
  logic [7:0]         out_age_out;

  // travels with the payload: use the typed-in reply instead of the prediction
  bit                   row_typed = 1'b0;
  srcache_pkg::result_t row_reply = '0;

  bit calm = 1'b0;
  int mismatch_count = 0;
  srcache_pkg::result_t reply_q[$];
  plan_row_t plan[$];

  // cache model state
  bit [srcache_pkg::SLOT_COUNT-1:0] occ;
  logic [63:0]         tag_mem   [srcache_pkg::SLOT_COUNT];
  logic [31:0]         score_mem [srcache_pkg::SLOT_COUNT];
  logic signed [7:0]   depth_mem [srcache_pkg::SLOT_COUNT];
  logic [1:0]          bound_mem [srcache_pkg::SLOT_COUNT];
  logic [15:0]         move_mem  [srcache_pkg::SLOT_COUNT];
  logic [7:0]          age_mem   [srcache_pkg::SLOT_COUNT];
  logic                tbl_en;
  logic [7:0]          cur_age;
  logic [30:0]         max_lim;

  search_result_cache_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_lookup_key (in_lookup_key),
    .in_depth      (in_depth),
    .in_ply        (in_ply),
    .in_score_in   (in_score_in),
    .in_bound_in   (in_bound_in),
    .in_move_in    (in_move_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_score_out (out_score_out),
    .out_depth_out (out_depth_out),
    .out_bound_out (out_bound_out),
    .out_move_out  (out_move_out),
    .out_age_out   (out_age_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 15);
  end

  // +1 for a winning mate score, -1 for a losing one, 0 otherwise
  function automatic int mate_side(input logic [31:0] s);
    longint v;
    longint lim;
    v   = longint'($signed(s));
    lim = longint'(max_lim);
    if (v > lim - longint'(srcache_pkg::MATE_WINDOW)) return 1;
    if (v < longint'(srcache_pkg::MATE_WINDOW) - lim) return -1;
    return 0;
  endfunction

  function automatic srcache_pkg::result_t predict_access(input srcache_pkg::req_t rq);
    srcache_pkg::result_t r;
    srcache_pkg::idx_t    i;
    logic [31:0]          s;
    int                   side;
    logic                 take;
    logic signed [7:0]    d;
    r = '0;
    i = rq.key[srcache_pkg::INDEX_BITS-1:0];
    d = rq.depth;
    if (rq.req_type == srcache_pkg::REQ_CLEAR) begin
      occ = '0;
      return r;
    end
    if (rq.req_type == REQ_SPARE || !tbl_en) return r;
    if (rq.req_type == srcache_pkg::REQ_PROBE) begin
      if (!occ[i] || tag_mem[i] != rq.key || depth_mem[i] < d) return r;
      s = score_mem[i];
      side = mate_side(s);
      // pull mate distance back toward the root
      if (side > 0) s = s - rq.ply;
      else if (side < 0) s = s + rq.ply;
      r.hit   = 1'b1;
      r.score = s;
      r.depth = depth_mem[i];
      r.bound = bound_mem[i];
      r.move  = move_mem[i];
      r.age   = age_mem[i];
      return r;
    end
    s = rq.score;
    side = mate_side(s);
    if (side > 0) s = s + rq.ply;
    else if (side < 0) s = s - rq.ply;
    if (!occ[i]) begin
      take = 1'b1;
    end else if (tag_mem[i] == rq.key) begin
      take = (d > depth_mem[i]) ||
             (d == depth_mem[i] && rq.bound == srcache_pkg::BOUND_EXACT &&
              bound_mem[i] != srcache_pkg::BOUND_EXACT);
    end else begin
      take = (age_mem[i] != cur_age) || (d >= depth_mem[i]) ||
             (rq.bound == srcache_pkg::BOUND_EXACT);
    end
    if (take) begin
      occ[i]       = 1'b1;
      tag_mem[i]   = rq.key;
      score_mem[i] = s;
      depth_mem[i] = d;
      bound_mem[i] = rq.bound;
      move_mem[i]  = rq.move;
      age_mem[i]   = cur_age;
      r.hit        = 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    srcache_pkg::result_t want;
    if (!rst_n) begin
      occ     = '0;
      tbl_en  = 1'b1;
      cur_age = '0;
      max_lim = srcache_pkg::SCORE_LIMIT_RST;
      reply_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          srcache_pkg::CFG_ENABLE:      tbl_en  = cfg_wdata[0];
          srcache_pkg::CFG_AGE:         cur_age = cfg_wdata[7:0];
          srcache_pkg::CFG_SCORE_LIMIT: max_lim = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          $display("%0t: result with no transaction outstanding, expected none, actual hit %0b",
                   $time, out_hit);
          mismatch_count++;
        end else begin
          want = reply_q.pop_front();
          check_field("hit", {31'd0, want.hit}, {31'd0, out_hit});
          check_field("score", want.score, out_score_out);
          check_field("depth", {24'd0, want.depth}, {24'd0, out_depth_out});
          check_field("bound", {30'd0, want.bound}, {30'd0, out_bound_out});
          check_field("move", {16'd0, want.move}, {16'd0, out_move_out});
          check_field("age", {24'd0, want.age}, {24'd0, out_age_out});
        end
      end
      if (in_valid && !in_stall) begin
        want = predict_access({in_req_type, in_lookup_key, in_depth, in_ply,
                               in_score_in, in_bound_in, in_move_in});
        if (row_typed) want = row_reply;
        reply_q.push_back(want);
      end
    end
  end

  // present one transaction and hold it until accepted
  task automatic issue_request(input srcache_pkg::req_t rq, input bit typed,
                               input srcache_pkg::result_t reply);
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= rq.req_type;
    in_lookup_key <= rq.key;
    in_depth      <= rq.depth;
    in_ply        <= rq.ply;
    in_score_in   <= rq.score;
    in_bound_in   <= rq.bound;
    in_move_in    <= rq.move;
    row_typed     <= typed;
    row_reply     <= reply;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input srcache_pkg::cfg_t regs);
    cfg_we    <= 1'b1;
    cfg_index <= srcache_pkg::CFG_ENABLE;
    cfg_wdata <= {30'd0, regs.enable};
    @(posedge clk);
    cfg_index <= srcache_pkg::CFG_AGE;
    cfg_wdata <= {23'd0, regs.age};
    @(posedge clk);
    cfg_index <= srcache_pkg::CFG_SCORE_LIMIT;
    cfg_wdata <= regs.score_limit;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic plan_row_t req_row(input logic [1:0] rt, input logic [63:0] key,
                                        input logic [7:0] dep, input logic [7:0] ply,
                                        input logic [31:0] sc, input logic [1:0] bnd,
                                        input logic [15:0] mv, input bit typed,
                                        input srcache_pkg::result_t reply);
    plan_row_t r;
    r.kind  = ROW_REQ;
    r.rq    = {rt, key, dep, ply, sc, bnd, mv};
    r.typed = typed;
    r.reply = reply;
    r.regs  = '0;
    return r;
  endfunction

  function automatic plan_row_t regs_row(input logic en, input logic [7:0] age,
                                         input logic [30:0] ms);
    plan_row_t r;
    r.kind  = ROW_REGS;
    r.rq    = '0;
    r.typed = PREDICTED;
    r.reply = MISS;
    r.regs  = {en, age, ms};
    return r;
  endfunction

  initial begin : stimulus
    logic [63:0]        key_pool [POOL_SIZE];
    srcache_pkg::req_t  rq;
    srcache_pkg::cfg_t  regs;
    longint             sc;
    longint             ph_max;
    int                 ph;
    int                 n;
    int                 j;

    // empty table, then mate shifts, replacement and wrap at the score limits
    plan.push_back(req_row(srcache_pkg::REQ_PROBE, KEY_ZERO, -8'sd128, 8'd0, 32'd0,
                           srcache_pkg::BOUND_EXACT, 16'h0000, TYPED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_STORE, KEY_ONE, 8'sd5, 8'd10, 32'sd999_950_000,
                           BOUND_LOWER, 16'hFFFF, TYPED, WROTE));
    plan.push_back(req_row(srcache_pkg::REQ_PROBE, KEY_ONE, 8'sd5, 8'd3, 32'd0,
                           srcache_pkg::BOUND_EXACT, 16'h0000, PREDICTED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_PROBE, KEY_ONE, 8'sd6, 8'd0, 32'd0,
                           srcache_pkg::BOUND_EXACT, 16'h0000, TYPED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_STORE, KEY_ONE, 8'sd5, 8'd0, 32'sd123,
                           srcache_pkg::BOUND_EXACT, 16'h1234, PREDICTED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_STORE, KEY_ONE, 8'sd5, 8'd0, 32'sd456,
                           BOUND_LOWER, 16'h0000, PREDICTED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_STORE, KEY_ONE_ALIAS, -8'sd128, 8'd0, 32'sd789,
                           BOUND_UPPER, 16'h0000, PREDICTED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_STORE, KEY_ONE_ALIAS, 8'sd5, 8'd1,
                           -32'sd999_950_000, BOUND_UPPER, 16'h5555, PREDICTED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_PROBE, KEY_ONES, -8'sd128, 8'd0, 32'd0,
                           srcache_pkg::BOUND_EXACT, 16'h0000, TYPED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_STORE, KEY_ONES, 8'sd127, 8'd255, 32'h8000_0000,
                           BOUND_ODD, 16'h0000, TYPED, WROTE));
    plan.push_back(req_row(srcache_pkg::REQ_PROBE, KEY_ONES, 8'sd127, 8'd255, 32'd0,
                           srcache_pkg::BOUND_EXACT, 16'h0000, PREDICTED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_STORE, KEY_ONES, 8'sd127, 8'd255, 32'h7FFF_FFFF,
                           srcache_pkg::BOUND_EXACT, 16'hFFFF, PREDICTED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_PROBE, KEY_ONES, -8'sd128, 8'd0, 32'd0,
                           srcache_pkg::BOUND_EXACT, 16'h0000, PREDICTED, MISS));
    plan.push_back(req_row(REQ_SPARE, KEY_ONES, 8'sd127, 8'd255, 32'h7FFF_FFFF,
                           BOUND_ODD, 16'hFFFF, TYPED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_PROBE, KEY_ONE_ALIAS, -8'sd128, 8'd9, 32'd0,
                           srcache_pkg::BOUND_EXACT, 16'h0000, PREDICTED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_CLEAR, KEY_ONES, -8'sd128, 8'd0, 32'd0,
                           srcache_pkg::BOUND_EXACT, 16'h0000, TYPED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_PROBE, KEY_ONES, -8'sd128, 8'd0, 32'd0,
                           srcache_pkg::BOUND_EXACT, 16'h0000, TYPED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_STORE, KEY_ONES, 8'sd3, 8'd0, 32'sd7,
                           BOUND_LOWER, 16'hAAAA, TYPED, WROTE));
    // disabled table: probe misses, store is dropped, clear still clears
    plan.push_back(regs_row(1'b0, 8'd255, srcache_pkg::SCORE_LIMIT_RST));
    plan.push_back(req_row(srcache_pkg::REQ_PROBE, KEY_ONES, -8'sd128, 8'd0, 32'd0,
                           srcache_pkg::BOUND_EXACT, 16'h0000, TYPED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_STORE, KEY_ZERO, 8'sd0, 8'd0, 32'd0,
                           srcache_pkg::BOUND_EXACT, 16'h0000, TYPED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_CLEAR, KEY_ZERO, 8'sd0, 8'd0, 32'd0,
                           srcache_pkg::BOUND_EXACT, 16'h0000, TYPED, MISS));
    plan.push_back(regs_row(1'b1, 8'd255, 31'd0));
    plan.push_back(req_row(srcache_pkg::REQ_PROBE, KEY_ONES, -8'sd128, 8'd0, 32'd0,
                           srcache_pkg::BOUND_EXACT, 16'h0000, TYPED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_STORE, KEY_ZERO, 8'sd0, 8'd7, 32'd0,
                           srcache_pkg::BOUND_EXACT, 16'h00FF, TYPED, WROTE));
    plan.push_back(req_row(srcache_pkg::REQ_PROBE, KEY_ZERO, 8'sd0, 8'd7, 32'd0,
                           srcache_pkg::BOUND_EXACT, 16'h0000, PREDICTED, MISS));
    plan.push_back(regs_row(1'b1, 8'd0, 31'h7FFF_FFFF));
    plan.push_back(req_row(srcache_pkg::REQ_STORE, KEY_ZERO, -8'sd1, 8'd9, 32'h8000_0000,
                           BOUND_LOWER, 16'h0F0F, PREDICTED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_STORE, KEY_ZERO_ALIAS, -8'sd128, 8'd200,
                           32'h8000_0000, BOUND_UPPER, 16'hF0F0, PREDICTED, MISS));
    plan.push_back(req_row(srcache_pkg::REQ_PROBE, KEY_ZERO_ALIAS, -8'sd128, 8'd200, 32'd0,
                           srcache_pkg::BOUND_EXACT, 16'h0000, PREDICTED, MISS));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < plan.size(); n++) begin
      if (plan[n].kind == ROW_REGS) begin
        wait_quiet();
        program_regs(plan[n].regs);
      end else begin
        issue_request(plan[n].rq, plan[n].typed, plan[n].reply);
      end
    end

    // half the pool aliases the slot of the other half
    for (j = 0; j < POOL_SIZE; j++) begin
      key_pool[j] = {$urandom, $urandom};
      if (j >= POOL_SIZE / 2)
        key_pool[j][srcache_pkg::INDEX_BITS-1:0] =
          key_pool[j - POOL_SIZE / 2][srcache_pkg::INDEX_BITS-1:0];
    end

    for (ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      calm = (ph == 6);
      for (j = 0; j < 4; j++) key_pool[$urandom_range(POOL_SIZE - 1)] = {$urandom, $urandom};
      regs.enable = (ph != 3);
      regs.age    = (ph == 1) ? 8'd255 : (ph == 2) ? 8'd0 : 8'($urandom);
      case (ph)
        0:       regs.score_limit = srcache_pkg::SCORE_LIMIT_RST;
        4:       regs.score_limit = 31'd0;
        5:       regs.score_limit = 31'h7FFF_FFFF;
        default: regs.score_limit = $urandom_range(1) ? 31'($urandom)
                                                      : 31'($urandom_range(300000));
      endcase
      ph_max = longint'(regs.score_limit);
      program_regs(regs);

      for (n = 0; n < PHASE_REQS; n++) begin
        j = $urandom_range(999);
        rq.req_type = (j < 10) ? srcache_pkg::REQ_CLEAR : (j < 25) ? REQ_SPARE :
                      (j < 500) ? srcache_pkg::REQ_PROBE : srcache_pkg::REQ_STORE;
        rq.key   = ($urandom_range(9) < 8) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                           : {$urandom, $urandom};
        rq.depth = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(12));
        rq.ply   = 8'($urandom);
        // aim scores at both edges of the mate windows and at the 32-bit limits
        case ($urandom_range(5))
          0:       sc = longint'($urandom);
          1:       sc = ph_max - longint'(srcache_pkg::MATE_WINDOW)
                        + longint'($urandom_range(4)) - 2;
          2:       sc = longint'(srcache_pkg::MATE_WINDOW) - ph_max
                        + longint'($urandom_range(4)) - 2;
          3:       sc = $urandom_range(1) ? 64'sh7FFF_FFFF : -64'sh8000_0000;
          4:       sc = ph_max - longint'($urandom_range(255));
          default: sc = longint'($urandom_range(2000)) - 1000;
        endcase
        rq.score = sc[31:0];
        rq.bound = 2'($urandom_range(3));
        rq.move  = 16'($urandom);
        issue_request(rq, PREDICTED, MISS);
      end
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/srcache_pkg.sv
rtl/srcache_ram.sv
rtl/srcache_decide.sv
rtl/search_result_cache_top.sv
dv/search_result_cache_top_test.sv
